/* hw/rtl/tpft_pkg.sv */
package tpft_pkg;

  localparam int CMD_RING_DEPTH_DEF  = 256;
  localparam int NORM_RING_DEPTH_DEF = 1024;
  localparam int JOB_QUEUE_DEPTH_DEF = 8;

  // request modes
  localparam logic [1:0] MODE_BYTE     = 2'd0;
  localparam logic [1:0] MODE_TX_READY = 2'd1;
  localparam logic [1:0] MODE_TX_DONE  = 2'd2;
  localparam logic [1:0] MODE_BUS_IDLE = 2'd3;

  // enqueue status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_DROP   = 2'd1;
  localparam logic [1:0] ST_REJECT = 2'd2;
  localparam logic [1:0] ST_NONE   = 2'd3;

  typedef enum logic [2:0] {
    K_FIRST,
    K_CONT,
    K_TX_READY,
    K_TX_DONE,
    K_BUS_IDLE
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_TX,
    S_PUMP,
    S_LOAD,
    S_OUT
  } back_state_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  data_byte;
    logic        first_of_frame;
    logic [15:0] frame_length;
    logic        urgent;
    logic        bus_idle;
  } item_t;

  typedef struct packed {
    logic [7:0]  tx_byte;
    logic        tx_valid;
    logic        frame_start;
    logic        start_priority;
    logic        frame_done;
    logic        awaiting_complete;
    logic        busy_res;
    logic [1:0]  enqueue_status;
    logic [15:0] drops;
  } result_t;

  // classified request as it waits between front and back
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data_byte;
    logic [15:0] frame_length;
    logic        urgent;
    logic        bus_idle;
  } cls_item_t;

endpackage

/* hw/rtl/tpft_ram.sv */
module tpft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/tpft_front.sv */
module tpft_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  tpft_pkg::item_t     item,
  output logic                q_valid,
  output tpft_pkg::cls_item_t q_head,
  input  logic                q_pop
);

  tpft_pkg::cls_item_t slot [2];
  tpft_pkg::cls_item_t cls;
  logic                wr_ptr;
  logic                rd_ptr;
  logic [1:0]          fill;
  logic [1:0]          fill_next;
  logic                push;

  always_comb begin
    cls.data_byte    = item.data_byte;
    cls.frame_length = item.frame_length;
    cls.urgent       = item.urgent;
    cls.bus_idle     = item.bus_idle;
    unique case (item.mode)
      tpft_pkg::MODE_BYTE:     cls.kind = item.first_of_frame ? tpft_pkg::K_FIRST
                                                              : tpft_pkg::K_CONT;
      tpft_pkg::MODE_TX_READY: cls.kind = tpft_pkg::K_TX_READY;
      tpft_pkg::MODE_TX_DONE:  cls.kind = tpft_pkg::K_TX_DONE;
      tpft_pkg::MODE_BUS_IDLE: cls.kind = tpft_pkg::K_BUS_IDLE;
      default:                 cls.kind = tpft_pkg::K_BUS_IDLE;
    endcase
  end

  assign item_ready = (fill != 2'd2);
  assign push       = item_valid && item_ready;
  assign q_valid    = (fill != 2'd0);
  assign q_head     = slot[rd_ptr];

  always_comb begin
    case ({push, q_pop})
      2'b10:   fill_next = fill + 2'd1;
      2'b01:   fill_next = fill - 2'd1;
      default: fill_next = fill;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      fill <= fill_next;
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= cls;
    end
  end

endmodule

/* hw/rtl/tpft_back.sv */
module tpft_back #(
  parameter int CMD_RING_DEPTH  = tpft_pkg::CMD_RING_DEPTH_DEF,
  parameter int NORM_RING_DEPTH = tpft_pkg::NORM_RING_DEPTH_DEF,
  parameter int JOB_QUEUE_DEPTH = tpft_pkg::JOB_QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  tpft_pkg::cls_item_t q_head,
  output logic                q_pop,
  input  logic                wait_for_shift_out,
  output logic                result_valid,
  input  logic                result_ready,
  output tpft_pkg::result_t   result
);

  localparam int CRW = $clog2(CMD_RING_DEPTH);
  localparam int NRW = $clog2(NORM_RING_DEPTH);
  localparam int LW  = (CRW > NRW) ? CRW : NRW;
  localparam int JAW = (JOB_QUEUE_DEPTH > 1) ? $clog2(JOB_QUEUE_DEPTH) : 1;
  localparam int JCW = $clog2(JOB_QUEUE_DEPTH + 1);

  tpft_pkg::back_state_t state, state_next;
  tpft_pkg::cls_item_t   itm, itm_next;

  logic [CRW-1:0] c_rd, c_rd_next, c_wr, c_wr_next, c_held, c_held_next;
  logic [NRW-1:0] n_rd, n_rd_next, n_wr, n_wr_next, n_held, n_held_next;
  logic [JAW-1:0] jh_c, jh_c_next, jt_c, jt_c_next, jh_n, jh_n_next, jt_n, jt_n_next;
  logic [JCW-1:0] jn_c, jn_c_next, jn_n, jn_n_next;

  logic           wr_open, wr_open_next, wr_drop, wr_drop_next, wr_prio, wr_prio_next;
  logic [15:0]    wr_rem, wr_rem_next;
  logic [LW-1:0]  wr_len, wr_len_next, wr_pos, wr_pos_next;

  logic [LW-1:0]  cur_len, cur_len_next, cur_sent, cur_sent_next;
  logic           cur_prio, cur_prio_next, sending, sending_next, waiting, waiting_next;
  logic [15:0]    drops, drops_next;
  logic           pump_idle, pump_idle_next;

  logic [1:0]     res_status, res_status_next;
  logic [7:0]     res_txb, res_txb_next;
  logic           res_txv, res_txv_next, res_fs, res_fs_next, res_fd, res_fd_next;

  logic              out_valid, out_valid_next;
  tpft_pkg::result_t out_data, out_data_next;

  // ring and job memory ports
  logic           cr_we, cr_re, nr_we, nr_re;
  logic [CRW-1:0] cr_waddr, cr_raddr;
  logic [NRW-1:0] nr_waddr, nr_raddr;
  logic [7:0]     cr_rdata, nr_rdata;
  logic           cj_we, cj_re, nj_we, nj_re;
  logic [JAW-1:0] cj_waddr, cj_raddr, nj_waddr, nj_raddr;
  logic [LW-1:0]  cj_rdata, nj_rdata, job_wdata;

  tpft_ram #(.WIDTH(8), .DEPTH(CMD_RING_DEPTH)) u_cmd_ring (
    .clk(clk), .we(cr_we), .waddr(cr_waddr), .wdata(itm.data_byte),
    .re(cr_re), .raddr(cr_raddr), .rdata(cr_rdata)
  );

  tpft_ram #(.WIDTH(8), .DEPTH(NORM_RING_DEPTH)) u_norm_ring (
    .clk(clk), .we(nr_we), .waddr(nr_waddr), .wdata(itm.data_byte),
    .re(nr_re), .raddr(nr_raddr), .rdata(nr_rdata)
  );

  tpft_ram #(.WIDTH(LW), .DEPTH(JOB_QUEUE_DEPTH)) u_cmd_jobs (
    .clk(clk), .we(cj_we), .waddr(cj_waddr), .wdata(job_wdata),
    .re(cj_re), .raddr(cj_raddr), .rdata(cj_rdata)
  );

  tpft_ram #(.WIDTH(LW), .DEPTH(JOB_QUEUE_DEPTH)) u_norm_jobs (
    .clk(clk), .we(nj_we), .waddr(nj_waddr), .wdata(job_wdata),
    .re(nj_re), .raddr(nj_raddr), .rdata(nj_rdata)
  );

  assign result_valid = out_valid;
  assign result       = out_data;

  always_comb begin
    logic [15:0]   free_bytes;
    logic          queue_full;
    logic          do_store;
    logic          do_commit;
    logic          store_prio;
    logic [LW-1:0] store_pos;
    logic [LW-1:0] pos_after;
    logic [LW-1:0] commit_len;
    logic          pick;

    state_next      = state;
    itm_next        = itm;
    c_rd_next       = c_rd;
    c_wr_next       = c_wr;
    c_held_next     = c_held;
    n_rd_next       = n_rd;
    n_wr_next       = n_wr;
    n_held_next     = n_held;
    jh_c_next       = jh_c;
    jt_c_next       = jt_c;
    jn_c_next       = jn_c;
    jh_n_next       = jh_n;
    jt_n_next       = jt_n;
    jn_n_next       = jn_n;
    wr_open_next    = wr_open;
    wr_drop_next    = wr_drop;
    wr_prio_next    = wr_prio;
    wr_rem_next     = wr_rem;
    wr_len_next     = wr_len;
    wr_pos_next     = wr_pos;
    cur_len_next    = cur_len;
    cur_sent_next   = cur_sent;
    cur_prio_next   = cur_prio;
    sending_next    = sending;
    waiting_next    = waiting;
    drops_next      = drops;
    pump_idle_next  = pump_idle;
    res_status_next = res_status;
    res_txb_next    = res_txb;
    res_txv_next    = res_txv;
    res_fs_next     = res_fs;
    res_fd_next     = res_fd;
    out_valid_next  = out_valid && !result_ready;
    out_data_next   = out_data;
    q_pop           = 1'b0;

    cr_we     = 1'b0;
    cr_waddr  = c_wr;
    cr_re     = 1'b0;
    cr_raddr  = c_rd;
    nr_we     = 1'b0;
    nr_waddr  = n_wr;
    nr_re     = 1'b0;
    nr_raddr  = n_rd;
    cj_we     = 1'b0;
    cj_waddr  = jt_c;
    cj_re     = 1'b0;
    cj_raddr  = jh_c;
    nj_we     = 1'b0;
    nj_waddr  = jt_n;
    nj_re     = 1'b0;
    nj_raddr  = jh_n;

    do_store   = 1'b0;
    do_commit  = 1'b0;
    store_prio = wr_prio;
    store_pos  = wr_pos;
    commit_len = wr_len;
    job_wdata  = commit_len;
    pos_after  = wr_pos;
    pick       = 1'b0;
    free_bytes = itm.urgent ? (16'(CMD_RING_DEPTH - 1) - 16'(c_held))
                            : (16'(NORM_RING_DEPTH - 1) - 16'(n_held));
    queue_full = itm.urgent ? (jn_c == JCW'(JOB_QUEUE_DEPTH))
                            : (jn_n == JCW'(JOB_QUEUE_DEPTH));

    unique case (state)
      tpft_pkg::S_IDLE: begin
        // only start once the output slot is free, so the result always has a home
        if (q_valid && (!out_valid || result_ready)) begin
          q_pop      = 1'b1;
          itm_next   = q_head;
          state_next = tpft_pkg::S_EXEC;
        end
      end

      tpft_pkg::S_EXEC: begin
        res_status_next = tpft_pkg::ST_NONE;
        res_txv_next    = 1'b0;
        res_fs_next     = 1'b0;
        res_fd_next     = 1'b0;
        state_next      = tpft_pkg::S_OUT;
        unique case (itm.kind)
          tpft_pkg::K_FIRST: begin
            // a new first byte abandons any open frame
            wr_open_next = 1'b0;
            wr_drop_next = 1'b0;
            if (itm.frame_length == 16'd0) begin
              res_status_next = tpft_pkg::ST_REJECT;
            end else if ((free_bytes < itm.frame_length) || queue_full) begin
              drops_next      = drops + 16'd1;
              res_status_next = tpft_pkg::ST_DROP;
              if (itm.frame_length > 16'd1) begin
                wr_open_next = 1'b1;
                wr_drop_next = 1'b1;
                wr_rem_next  = itm.frame_length - 16'd1;
              end
            end else begin
              res_status_next = tpft_pkg::ST_OK;
              wr_prio_next    = itm.urgent;
              wr_len_next     = itm.frame_length[LW-1:0];
              wr_rem_next     = itm.frame_length - 16'd1;
              wr_open_next    = 1'b1;
              do_store        = 1'b1;
              store_prio      = itm.urgent;
              store_pos       = itm.urgent ? LW'(c_wr) : LW'(n_wr);
              commit_len      = itm.frame_length[LW-1:0];
              do_commit       = (itm.frame_length == 16'd1);
            end
          end

          tpft_pkg::K_CONT: begin
            if (!wr_open) begin
              res_status_next = tpft_pkg::ST_REJECT;
            end else if (wr_drop) begin
              wr_rem_next = wr_rem - 16'd1;
              if (wr_rem == 16'd1) begin
                wr_open_next = 1'b0;
                wr_drop_next = 1'b0;
              end
            end else begin
              res_status_next = tpft_pkg::ST_OK;
              do_store        = 1'b1;
              wr_rem_next     = wr_rem - 16'd1;
              do_commit       = (wr_rem == 16'd1);
            end
          end

          tpft_pkg::K_TX_READY: begin
            if (sending && !waiting && (cur_sent < cur_len)) begin
              if (cur_prio) begin
                cr_re     = 1'b1;
                c_rd_next = (c_rd == CRW'(CMD_RING_DEPTH - 1)) ? '0 : c_rd + 1'b1;
                if (c_held != '0) begin
                  c_held_next = c_held - 1'b1;
                end
              end else begin
                nr_re     = 1'b1;
                n_rd_next = (n_rd == NRW'(NORM_RING_DEPTH - 1)) ? '0 : n_rd + 1'b1;
                if (n_held != '0) begin
                  n_held_next = n_held - 1'b1;
                end
              end
              cur_sent_next = cur_sent + 1'b1;
              res_txv_next  = 1'b1;
              if ((cur_sent + 1'b1) == cur_len) begin
                if (wait_for_shift_out) begin
                  waiting_next = 1'b1;
                end else begin
                  sending_next = 1'b0;
                  res_fd_next  = 1'b1;
                end
              end
              state_next = tpft_pkg::S_TX;
            end
          end

          tpft_pkg::K_TX_DONE: begin
            if (waiting) begin
              waiting_next = 1'b0;
              sending_next = 1'b0;
              res_fd_next  = 1'b1;
            end
          end

          tpft_pkg::K_BUS_IDLE: begin
            pump_idle_next = 1'b1;
            state_next     = tpft_pkg::S_PUMP;
          end

          default: state_next = tpft_pkg::S_OUT;
        endcase
      end

      tpft_pkg::S_TX: begin
        res_txb_next = cur_prio ? cr_rdata : nr_rdata;
        state_next   = tpft_pkg::S_OUT;
      end

      tpft_pkg::S_PUMP: begin
        // command jobs always go first
        state_next = tpft_pkg::S_OUT;
        if (!sending && pump_idle && ((jn_c != '0) || (jn_n != '0))) begin
          pick = (jn_c != '0);
          if (pick) begin
            cj_re     = 1'b1;
            jh_c_next = (jh_c == JAW'(JOB_QUEUE_DEPTH - 1)) ? '0 : jh_c + 1'b1;
            jn_c_next = jn_c - 1'b1;
          end else begin
            nj_re     = 1'b1;
            jh_n_next = (jh_n == JAW'(JOB_QUEUE_DEPTH - 1)) ? '0 : jh_n + 1'b1;
            jn_n_next = jn_n - 1'b1;
          end
          cur_prio_next = pick;
          cur_sent_next = '0;
          sending_next  = 1'b1;
          waiting_next  = 1'b0;
          res_fs_next   = 1'b1;
          state_next    = tpft_pkg::S_LOAD;
        end
      end

      tpft_pkg::S_LOAD: begin
        cur_len_next = cur_prio ? cj_rdata : nj_rdata;
        state_next   = tpft_pkg::S_OUT;
      end

      tpft_pkg::S_OUT: begin
        out_valid_next                 = 1'b1;
        out_data_next.tx_byte          = res_txv ? res_txb : 8'd0;
        out_data_next.tx_valid         = res_txv;
        out_data_next.frame_start      = res_fs;
        out_data_next.start_priority   = (sending || res_fd) ? cur_prio : 1'b0;
        out_data_next.frame_done       = res_fd;
        out_data_next.awaiting_complete = waiting;
        out_data_next.busy_res         = sending;
        out_data_next.enqueue_status   = res_status;
        out_data_next.drops            = drops;
        state_next                     = tpft_pkg::S_IDLE;
      end

      default: state_next = tpft_pkg::S_IDLE;
    endcase

    // byte staging, then commit of a complete frame into its ring and job queue
    if (do_store) begin
      if (store_prio) begin
        cr_we     = 1'b1;
        cr_waddr  = store_pos[CRW-1:0];
        pos_after = (store_pos[CRW-1:0] == CRW'(CMD_RING_DEPTH - 1)) ? '0
                    : LW'(store_pos[CRW-1:0] + 1'b1);
      end else begin
        nr_we     = 1'b1;
        nr_waddr  = store_pos[NRW-1:0];
        pos_after = (store_pos[NRW-1:0] == NRW'(NORM_RING_DEPTH - 1)) ? '0
                    : LW'(store_pos[NRW-1:0] + 1'b1);
      end
      wr_pos_next = pos_after;
    end

    job_wdata = commit_len;
    if (do_commit) begin
      if (store_prio) begin
        c_wr_next   = pos_after[CRW-1:0];
        c_held_next = c_held + commit_len[CRW-1:0];
        cj_we       = 1'b1;
        jt_c_next   = (jt_c == JAW'(JOB_QUEUE_DEPTH - 1)) ? '0 : jt_c + 1'b1;
        jn_c_next   = jn_c + 1'b1;
      end else begin
        n_wr_next   = pos_after[NRW-1:0];
        n_held_next = n_held + commit_len[NRW-1:0];
        nj_we       = 1'b1;
        jt_n_next   = (jt_n == JAW'(JOB_QUEUE_DEPTH - 1)) ? '0 : jt_n + 1'b1;
        jn_n_next   = jn_n + 1'b1;
      end
      wr_open_next   = 1'b0;
      pump_idle_next = itm.bus_idle;
      state_next     = tpft_pkg::S_PUMP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tpft_pkg::S_IDLE;
      c_rd      <= '0;
      c_wr      <= '0;
      c_held    <= '0;
      n_rd      <= '0;
      n_wr      <= '0;
      n_held    <= '0;
      jh_c      <= '0;
      jt_c      <= '0;
      jn_c      <= '0;
      jh_n      <= '0;
      jt_n      <= '0;
      jn_n      <= '0;
      wr_open   <= 1'b0;
      wr_drop   <= 1'b0;
      cur_len   <= '0;
      cur_sent  <= '0;
      cur_prio  <= 1'b0;
      sending   <= 1'b0;
      waiting   <= 1'b0;
      drops     <= 16'd0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      c_rd      <= c_rd_next;
      c_wr      <= c_wr_next;
      c_held    <= c_held_next;
      n_rd      <= n_rd_next;
      n_wr      <= n_wr_next;
      n_held    <= n_held_next;
      jh_c      <= jh_c_next;
      jt_c      <= jt_c_next;
      jn_c      <= jn_c_next;
      jh_n      <= jh_n_next;
      jt_n      <= jt_n_next;
      jn_n      <= jn_n_next;
      wr_open   <= wr_open_next;
      wr_drop   <= wr_drop_next;
      cur_len   <= cur_len_next;
      cur_sent  <= cur_sent_next;
      cur_prio  <= cur_prio_next;
      sending   <= sending_next;
      waiting   <= waiting_next;
      drops     <= drops_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    itm        <= itm_next;
    wr_prio    <= wr_prio_next;
    wr_rem     <= wr_rem_next;
    wr_len     <= wr_len_next;
    wr_pos     <= wr_pos_next;
    pump_idle  <= pump_idle_next;
    res_status <= res_status_next;
    res_txb    <= res_txb_next;
    res_txv    <= res_txv_next;
    res_fs     <= res_fs_next;
    res_fd     <= res_fd_next;
    out_data   <= out_data_next;
  end

endmodule

/* hw/rtl/two_priority_frame_transmitter_unit.sv */
// Two-priority frame transmitter. Requests (frame bytes, transmitter ready, transmit
// complete, bus idle) are classified and held in a two-entry queue, so the block keeps
// taking requests while a result waits on the output register. The back end takes a
// request from the queue only once the output register is free or being read, and handles
// one request at a time: most requests pass through an execute and an output state, a byte
// sent to the line adds a state for the registered read of the ring memory, a completed
// frame or a bus-idle request adds a pump state, and a started job adds a load state for
// the registered read of the job queue memory. Every request gives exactly one result.
// Frames of nonzero length are admitted only if their ring has room and their job queue
// is not full; otherwise they are dropped and counted. Command jobs always go out before
// normal jobs. No clearing pass is needed after reset.
module two_priority_frame_transmitter_unit #(
  parameter int CMD_RING_DEPTH  = tpft_pkg::CMD_RING_DEPTH_DEF,
  parameter int NORM_RING_DEPTH = tpft_pkg::NORM_RING_DEPTH_DEF,
  parameter int JOB_QUEUE_DEPTH = tpft_pkg::JOB_QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  tpft_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_ready,
  output tpft_pkg::result_t result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_data
);

  logic                wait_for_shift_out;
  logic                q_valid;
  logic                q_pop;
  tpft_pkg::cls_item_t q_head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      wait_for_shift_out <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      wait_for_shift_out <= cfg_data;
    end
  end

  tpft_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop)
  );

  tpft_back #(
    .CMD_RING_DEPTH  (CMD_RING_DEPTH),
    .NORM_RING_DEPTH (NORM_RING_DEPTH),
    .JOB_QUEUE_DEPTH (JOB_QUEUE_DEPTH)
  ) u_back (
    .clk                (clk),
    .rst                (rst),
    .q_valid            (q_valid),
    .q_head             (q_head),
    .q_pop              (q_pop),
    .wait_for_shift_out (wait_for_shift_out),
    .result_valid       (result_valid),
    .result_ready       (result_ready),
    .result             (result)
  );

endmodule

/* hw/rtl/tpft_checker.sv */
module tpft_checker (
  input logic              clk,
  input logic              rst,
  input logic              item_valid,
  input logic              item_ready,
  input logic              result_valid,
  input logic              result_ready,
  input tpft_pkg::result_t result
);

  logic [2:0]  pending;
  logic [15:0] last_drops;
  logic        in_acc;
  logic        out_acc;

  assign in_acc  = item_valid && item_ready;
  assign out_acc = result_valid && result_ready;

  // requests taken but not yet answered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending    <= 3'd0;
      last_drops <= 16'd0;
    end else begin
      pending <= pending + {2'b00, in_acc} - {2'b00, out_acc};
      if (out_acc) begin
        last_drops <= result.drops;
      end
    end
  end

  a_reset_quiet: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("stalled result changed");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> pending != 3'd0)
    else $error("result without an outstanding request");

  a_drops_step: assert property (@(posedge clk) disable iff (rst)
    out_acc |-> (result.drops == last_drops) || (result.drops == last_drops + 16'd1))
    else $error("drop counter jumped");

  a_drops_status: assert property (@(posedge clk) disable iff (rst)
    out_acc |-> ((result.enqueue_status == tpft_pkg::ST_DROP) == (result.drops != last_drops)))
    else $error("drop count and status disagree");

endmodule

bind two_priority_frame_transmitter_unit tpft_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_ready   (item_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);
